@@ rtl/mslc_pkg.sv @@
// types and codes shared by the mesi line controller modules
package mslc_pkg;

  // coherence state of one line, stable and transient
  typedef enum logic [2:0] {
    ST_I   = 3'd0,
    ST_S   = 3'd1,
    ST_E   = 3'd2,
    ST_M   = 3'd3,
    ST_IM  = 3'd4,
    ST_ISE = 3'd5,
    ST_SM  = 3'd6
  } line_state_e;

  // kind of incoming item
  typedef enum logic [2:0] {
    K_LOAD  = 3'd0,
    K_STORE = 3'd1,
    K_GETS  = 3'd2,
    K_GETM  = 3'd3,
    K_DATA  = 3'd4
  } kind_e;

  // request placed on the bus
  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_GETS = 2'd1,
    BUS_GETM = 2'd2
  } bus_req_e;

  // actions decided for one item
  typedef struct packed {
    bus_req_e    bus_req;
    logic        to_proc;
    logic        on_bus;
    logic        shared;
    logic        err;
    logic        miss;
    logic        upgrade;
    line_state_e next_state;
  } act_t;

endpackage

@@ rtl/mesi_snooping_line_controller.sv @@
// mesi snooping line controller top level: control, output register and counters
//
// Usage:
//  - input channel (in_valid_i / in_stall_o) carries one processor load or store,
//    or one snooped GETS, GETM or DATA, for the line given by line_index_i
//  - output channel (out_valid_o / out_stall_i) returns exactly one result item
//    per input item, in order, with the bus actions, the new line state and the
//    running miss and silent-upgrade totals
//  - a result is written to the output register after its item's table read
//  - the line state table has one synchronous read port, so an item is read
//    and then written back as its result is registered, and one item is in
//    flight at a time; a new item is taken only after that write-back
//  - the output register lets a new item be read while an earlier result
//    still waits; a result held by out_stall_i blocks only the write-back of
//    the item behind it, which then keeps in_stall_o high
//  - reset: counters clear and the table is swept to Invalid, one line per
//    cycle, from line 0 up to line LINES-1; in_stall_o stays high
//    throughout the sweep
//  - a line index at or above LINES is reported as a protocol error
module mesi_snooping_line_controller #(
  parameter int unsigned LINES     = 1024,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [9:0]  line_index_i,
  input  logic [31:0] address_i,
  input  logic [3:0]  requester_i,
  input  logic        shared_seen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] address_out_o,
  output logic [1:0]  bus_request_o,
  output logic        data_to_processor_o,
  output logic        data_on_bus_o,
  output logic [3:0]  data_destination_o,
  output logic        assert_shared_o,
  output logic        protocol_error_o,
  output logic [2:0]  new_line_state_o,
  output logic        was_miss_o,
  output logic        was_silent_upgrade_o,
  output logic [31:0] miss_total_o,
  output logic [31:0] upgrade_total_o
);
  import mslc_pkg::*;

  localparam int unsigned IdxW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned ExtW = (IdxW > 10) ? IdxW : 10;
  localparam int unsigned AddrW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  logic            accept, complete, out_take, init_busy;
  logic            busy_q;
  logic [ExtW-1:0] idx_ext;
  logic            in_range;

  // item held during the table read
  kind_e            kind_q;
  logic [IdxW-1:0]  idx_q;
  logic             in_range_q;
  logic [AddrW-1:0] addr_q;
  logic [3:0]       req_q;
  logic             shared_q;

  line_state_e rd_state;
  act_t        act;
  logic        any_msg;

  // output register
  logic             out_valid_q;
  logic [AddrW-1:0] o_addr_q;
  bus_req_e         o_bus_q;
  logic             o_to_proc_q, o_on_bus_q, o_shared_q, o_err_q, o_miss_q, o_upg_q;
  logic [3:0]       o_dest_q;
  line_state_e      o_state_q;
  logic [31:0]      miss_cnt_q, upg_cnt_q;

  // handshake
  assign in_stall_o = busy_q | init_busy;
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_q & ~out_stall_i;
  assign complete   = busy_q & (~out_valid_q | ~out_stall_i);

  // line index range check
  assign idx_ext  = ExtW'(line_index_i);
  assign in_range = (32'(line_index_i) < 32'(LINES));

  mslc_state_mem #(
    .LINES (LINES)
  ) u_state_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (idx_ext[IdxW-1:0]),
    .rd_data_o   (rd_state),
    .wr_en_i     (complete & in_range_q & ~act.err),
    .wr_addr_i   (idx_q),
    .wr_data_i   (act.next_state),
    .init_busy_o (init_busy)
  );

  mslc_next_state u_next_state (
    .kind_i        (kind_q),
    .state_i       (rd_state),
    .shared_seen_i (shared_q),
    .in_range_i    (in_range_q),
    .act_o         (act)
  );

  assign any_msg = (act.bus_req != BUS_NONE) | act.to_proc | act.on_bus;

  // capture item fields on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_e'(kind_i);
      idx_q      <= idx_ext[IdxW-1:0];
      in_range_q <= in_range;
      addr_q     <= address_i[AddrW-1:0];
      req_q      <= requester_i;
      shared_q   <= shared_seen_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (complete) begin
      o_addr_q    <= any_msg ? addr_q : '0;
      o_bus_q     <= act.bus_req;
      o_to_proc_q <= act.to_proc;
      o_on_bus_q  <= act.on_bus;
      o_dest_q    <= act.on_bus ? req_q : 4'd0;
      o_shared_q  <= act.shared;
      o_err_q     <= act.err;
      o_state_q   <= act.next_state;
      o_miss_q    <= act.miss;
      o_upg_q     <= act.upgrade;
    end
  end

  // control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      miss_cnt_q  <= '0;
      upg_cnt_q   <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (complete) begin
        busy_q <= 1'b0;
      end
      if (complete) begin
        out_valid_q <= 1'b1;
        miss_cnt_q  <= miss_cnt_q + 32'(act.miss);
        upg_cnt_q   <= upg_cnt_q + 32'(act.upgrade);
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output ports
  assign out_valid_o          = out_valid_q;
  assign address_out_o        = 32'(o_addr_q);
  assign bus_request_o        = o_bus_q;
  assign data_to_processor_o  = o_to_proc_q;
  assign data_on_bus_o        = o_on_bus_q;
  assign data_destination_o   = o_dest_q;
  assign assert_shared_o      = o_shared_q;
  assign protocol_error_o     = o_err_q;
  assign new_line_state_o     = o_state_q;
  assign was_miss_o           = o_miss_q;
  assign was_silent_upgrade_o = o_upg_q;
  assign miss_total_o         = miss_cnt_q;
  assign upgrade_total_o      = upg_cnt_q;

  // checks
  a_err_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_err_q |-> o_bus_q == BUS_NONE && !o_to_proc_q && !o_on_bus_q
      && !o_miss_q && !o_upg_q)
    else $error("protocol error result carries an action");

  a_upgrade_to_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_upg_q |-> o_state_q == ST_M && o_to_proc_q)
    else $error("silent upgrade did not end in M");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete |=> miss_cnt_q == $past(miss_cnt_q) + 32'($past(act.miss)))
    else $error("miss total out of step");

  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !busy_q && !out_valid_q)
    else $error("item in flight during table clearing");

endmodule

@@ rtl/mslc_state_mem.sv @@
// line state table: synchronous memory with registered read data and a clearing sweep after reset
module mslc_state_mem #(
  parameter int unsigned LINES = 1024,
  localparam int unsigned IdxW = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [IdxW-1:0]        rd_addr_i,
  output mslc_pkg::line_state_e  rd_data_o,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_addr_i,
  input  mslc_pkg::line_state_e  wr_data_i,
  output logic                   init_busy_o
);
  import mslc_pkg::*;

  line_state_e mem [LINES];
  line_state_e rd_data_q;
  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;
  logic clearing_q, clearing_d;
  logic we;
  logic [IdxW-1:0] waddr;
  line_state_e wdata;

  // clearing sweep: one entry per cycle from zero to the last line
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + IdxW'(1);
      if (clr_cnt_q == IdxW'(LINES - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clearing_q <= clearing_d;
    end
  end

  // write port shared between the sweep and the item write-back
  always_comb begin
    we    = clearing_q | wr_en_i;
    waddr = clearing_q ? clr_cnt_q : wr_addr_i;
    wdata = clearing_q ? ST_I : wr_data_i;
  end

  // storage with registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o   = rd_data_q;
  assign init_busy_o = clearing_q;

endmodule

@@ rtl/mslc_next_state.sv @@
// mesi transition logic for one item against the line's current state
module mslc_next_state (
  input  mslc_pkg::kind_e       kind_i,
  input  mslc_pkg::line_state_e state_i,
  input  logic                  shared_seen_i,
  input  logic                  in_range_i,
  output mslc_pkg::act_t        act_o
);
  import mslc_pkg::*;

  act_t act;

  always_comb begin
    act            = '0;
    act.next_state = state_i;
    if (!in_range_i) begin
      // line outside the table
      act.err        = 1'b1;
      act.next_state = ST_I;
    end else begin
      unique case (kind_i) inside
        K_LOAD, K_STORE: begin
          // processor request
          case (state_i)
            ST_I: begin
              act.bus_req    = (kind_i == K_STORE) ? BUS_GETM : BUS_GETS;
              act.next_state = (kind_i == K_STORE) ? ST_IM : ST_ISE;
              act.miss       = 1'b1;
            end
            ST_S: begin
              if (kind_i == K_STORE) begin
                act.bus_req    = BUS_GETM;
                act.next_state = ST_SM;
                act.miss       = 1'b1;
              end else begin
                act.to_proc = 1'b1;
              end
            end
            ST_E: begin
              act.to_proc = 1'b1;
              if (kind_i == K_STORE) begin
                act.next_state = ST_M;
                act.upgrade    = 1'b1;
              end
            end
            ST_M: begin
              act.to_proc = 1'b1;
            end
            default: begin
              act.err = 1'b1;
            end
          endcase
        end
        K_GETS, K_GETM: begin
          // snooped request from another module
          case (state_i) inside
            ST_S: begin
              if (kind_i == K_GETM) act.next_state = ST_I;
              else act.shared = 1'b1;
            end
            ST_E, ST_M: begin
              act.on_bus = 1'b1;
              if (kind_i == K_GETM) begin
                act.next_state = ST_I;
              end else begin
                act.next_state = ST_S;
                act.shared     = 1'b1;
              end
            end
            ST_SM: begin
              if (kind_i == K_GETM) act.next_state = ST_IM;
              else act.shared = 1'b1;
            end
            default: begin
            end
          endcase
        end
        K_DATA: begin
          // fill ends a transient state; ignored in I, an error in another stable state
          case (state_i) inside
            ST_I: begin
            end
            ST_IM, ST_SM: begin
              act.to_proc    = 1'b1;
              act.next_state = ST_M;
            end
            ST_ISE: begin
              act.to_proc    = 1'b1;
              act.next_state = shared_seen_i ? ST_S : ST_E;
            end
            default: begin
              act.err = 1'b1;
            end
          endcase
        end
        default: begin
          act.err = 1'b1;
        end
      endcase
    end
    // an illegal item has no effect
    if (act.err) begin
      act.bus_req = BUS_NONE;
      act.to_proc = 1'b0;
      act.on_bus  = 1'b0;
      act.shared  = 1'b0;
      act.miss    = 1'b0;
      act.upgrade = 1'b0;
      if (in_range_i) act.next_state = state_i;
    end
  end

  assign act_o = act;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for the mesi snooping line controller, with a line state predictor
module tb_top;
  import mslc_pkg::*;

  localparam int NUM_LINES      = 1024;
  localparam int HOT_LINES      = 10;
  localparam int RANDOM_ITEMS   = 760;
  localparam int WATCHDOG_LIMIT = 4000;

  // one request as presented on the input channel
  typedef struct {
    logic [2:0]  kind;
    logic [9:0]  idx;
    logic [31:0] addr;
    logic [3:0]  requester;
    logic        shared;
  } coh_request_t;

  // one result as returned on the output channel
  typedef struct {
    logic [31:0] addr;
    bus_req_e    bus;
    logic        to_proc;
    logic        on_bus;
    logic [3:0]  dest;
    logic        shared;
    logic        err;
    line_state_e nstate;
    logic        miss;
    logic        upg;
    logic [31:0] miss_total;
    logic [31:0] upg_total;
  } coh_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic [9:0]  line_index = '0;
  logic [31:0] address = '0;
  logic [3:0]  requester = '0;
  logic        shared_seen = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] address_out;
  logic [1:0]  bus_request;
  logic        data_to_processor;
  logic        data_on_bus;
  logic [3:0]  data_destination;
  logic        assert_shared;
  logic        protocol_error;
  logic [2:0]  new_line_state;
  logic        was_miss;
  logic        was_silent_upgrade;
  logic [31:0] miss_total;
  logic [31:0] upgrade_total;

  // predictor state
  line_state_e line_shadow [NUM_LINES] = '{default: ST_I};
  logic [31:0] misses_so_far = '0;
  logic [31:0] upgrades_so_far = '0;

  coh_request_t requests_queued [$];
  coh_outcome_t outcomes_due [$];
  logic [9:0]   hot_lines [HOT_LINES];

  int           failures = 0;
  int           idle_cycles = 0;
  logic [31:0]  cycle_count = '0;
  logic         in_took = 1'b0;
  logic         took_any;
  logic         quiet;
  int           gap_left = 0;
  int           stall_left = 0;
  coh_request_t seen_req;
  coh_request_t next_req;
  coh_outcome_t want;

  mesi_snooping_line_controller DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .kind_i               (kind),
    .line_index_i         (line_index),
    .address_i            (address),
    .requester_i          (requester),
    .shared_seen_i        (shared_seen),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .address_out_o        (address_out),
    .bus_request_o        (bus_request),
    .data_to_processor_o  (data_to_processor),
    .data_on_bus_o        (data_on_bus),
    .data_destination_o   (data_destination),
    .assert_shared_o      (assert_shared),
    .protocol_error_o     (protocol_error),
    .new_line_state_o     (new_line_state),
    .was_miss_o           (was_miss),
    .was_silent_upgrade_o (was_silent_upgrade),
    .miss_total_o         (miss_total),
    .upgrade_total_o      (upgrade_total)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // next coherence state and bus actions for one request, updating the shadow table
  function automatic coh_outcome_t predict_line_step(input coh_request_t r);
    coh_outcome_t o;
    line_state_e  cur;
    line_state_e  nxt;
    logic         is_store;
    logic         is_getm;
    cur = line_shadow[r.idx];
    nxt = cur;
    is_store = (r.kind == K_STORE);
    is_getm = (r.kind == K_GETM);
    o.bus = BUS_NONE;
    o.to_proc = 1'b0;
    o.on_bus = 1'b0;
    o.shared = 1'b0;
    o.err = 1'b0;
    o.miss = 1'b0;
    o.upg = 1'b0;
    case (r.kind)
      K_LOAD, K_STORE: begin
        case (cur)
          ST_I: begin
            o.bus = is_store ? BUS_GETM : BUS_GETS;
            nxt = is_store ? ST_IM : ST_ISE;
            o.miss = 1'b1;
          end
          ST_S: begin
            if (is_store) begin
              o.bus = BUS_GETM;
              nxt = ST_SM;
              o.miss = 1'b1;
            end else begin
              o.to_proc = 1'b1;
            end
          end
          ST_E: begin
            o.to_proc = 1'b1;
            if (is_store) begin
              nxt = ST_M;
              o.upg = 1'b1;
            end
          end
          ST_M: o.to_proc = 1'b1;
          // processor request while a transaction is pending
          default: o.err = 1'b1;
        endcase
      end
      K_GETS, K_GETM: begin
        case (cur)
          ST_S: begin
            if (is_getm) nxt = ST_I;
            else o.shared = 1'b1;
          end
          ST_E, ST_M: begin
            o.on_bus = 1'b1;
            if (is_getm) begin
              nxt = ST_I;
            end else begin
              nxt = ST_S;
              o.shared = 1'b1;
            end
          end
          ST_SM: begin
            if (is_getm) nxt = ST_IM;
            else o.shared = 1'b1;
          end
          default: ;
        endcase
      end
      K_DATA: begin
        case (cur)
          ST_I: ;
          ST_IM, ST_SM: begin
            o.to_proc = 1'b1;
            nxt = ST_M;
          end
          ST_ISE: begin
            o.to_proc = 1'b1;
            nxt = r.shared ? ST_S : ST_E;
          end
          // fill for a line already stable
          default: o.err = 1'b1;
        endcase
      end
      // unused kind codes
      default: o.err = 1'b1;
    endcase
    if (!o.err) begin
      line_shadow[r.idx] = nxt;
      if (o.miss) misses_so_far = misses_so_far + 32'd1;
      if (o.upg) upgrades_so_far = upgrades_so_far + 32'd1;
    end else begin
      nxt = cur;
    end
    o.nstate = nxt;
    o.dest = o.on_bus ? r.requester : 4'd0;
    o.addr = (o.bus != BUS_NONE || o.to_proc || o.on_bus) ? r.addr : 32'd0;
    o.miss_total = misses_so_far;
    o.upg_total = upgrades_so_far;
    return o;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_request(input logic [2:0] k, input logic [9:0] ln,
                               input logic [31:0] a, input logic [3:0] rq, input logic sh);
    coh_request_t r;
    r.kind = k;
    r.idx = ln;
    r.addr = a;
    r.requester = rq;
    r.shared = sh;
    requests_queued.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      failures++;
    end
  endtask

  // monitor: takes accepted items into the predictor, checks accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      took_any = 1'b0;
      if (in_valid && !in_stall) begin
        seen_req.kind = kind;
        seen_req.idx = line_index;
        seen_req.addr = address;
        seen_req.requester = requester;
        seen_req.shared = shared_seen;
        outcomes_due.push_back(predict_line_step(seen_req));
        took_any = 1'b1;
      end
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        took_any = 1'b1;
        if (outcomes_due.size() == 0) begin
          $error("result item with no request outstanding");
          failures++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("address_out", want.addr, address_out);
          check_field("bus_request", want.bus, bus_request);
          check_field("data_to_processor", want.to_proc, data_to_processor);
          check_field("data_on_bus", want.on_bus, data_on_bus);
          check_field("data_destination", want.dest, data_destination);
          check_field("assert_shared", want.shared, assert_shared);
          check_field("protocol_error", want.err, protocol_error);
          check_field("new_line_state", want.nstate, new_line_state);
          check_field("was_miss", want.miss, was_miss);
          check_field("was_silent_upgrade", want.upg, was_silent_upgrade);
          check_field("miss_total", want.miss_total, miss_total);
          check_field("upgrade_total", want.upg_total, upgrade_total);
        end
      end
      cycle_count <= cycle_count + 32'd1;
      idle_cycles = took_any ? 0 : idle_cycles + 1;
      // watchdog, covers the reset sweep as well
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // driver: presents queued items with random gaps, random result stalls
  always @(negedge clk) begin
    quiet = (cycle_count[8:7] == 2'b00);
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (requests_queued.size() > 0) begin
        next_req = requests_queued.pop_front();
        kind <= next_req.kind;
        line_index <= next_req.idx;
        address <= next_req.addr;
        requester <= next_req.requester;
        shared_seen <= next_req.shared;
        in_valid <= 1'b1;
        gap_left = quiet ? 0 : draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = quiet ? 0 : draw_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int          n;
    int          r;
    int          k;
    logic [2:0]  kd;
    logic [9:0]  ln;

    hot_lines[0] = 10'd0;
    hot_lines[1] = 10'd1023;
    for (int i = 2; i < HOT_LINES; i++) hot_lines[i] = 10'($urandom);

    // directed walk through line 0
    queue_request(K_DATA,  10'd0, $urandom, 4'($urandom), 1'b1);   // fill in I is ignored
    queue_request(K_LOAD,  10'd0, 32'hFFFF_FFFF, 4'($urandom), 1'b0);
    queue_request(K_STORE, 10'd0, $urandom, 4'($urandom), 1'b0);   // request while pending
    queue_request(K_GETS,  10'd0, $urandom, 4'($urandom), 1'b0);
    queue_request(K_DATA,  10'd0, $urandom, 4'($urandom), 1'b0);   // no sharer, to E
    queue_request(K_DATA,  10'd0, $urandom, 4'($urandom), 1'b0);   // fill in stable state
    queue_request(K_STORE, 10'd0, $urandom, 4'($urandom), 1'b0);   // silent upgrade
    queue_request(K_GETS,  10'd0, $urandom, 4'd15, 1'b0);
    queue_request(K_STORE, 10'd0, $urandom, 4'($urandom), 1'b0);   // S to SM
    queue_request(K_GETS,  10'd0, $urandom, 4'($urandom), 1'b0);
    queue_request(K_GETM,  10'd0, $urandom, 4'($urandom), 1'b0);   // SM to IM
    queue_request(K_DATA,  10'd0, 32'd0, 4'($urandom), 1'b1);
    queue_request(K_GETM,  10'd0, $urandom, 4'd0, 1'b0);
    // directed walk through the top line
    queue_request(K_LOAD,  10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_DATA,  10'd1023, $urandom, 4'($urandom), 1'b1); // sharer seen, to S
    queue_request(K_LOAD,  10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_GETM,  10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_STORE, 10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_LOAD,  10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_GETS,  10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_DATA,  10'd1023, $urandom, 4'($urandom), 1'b0);
    queue_request(K_LOAD,  10'd1023, $urandom, 4'($urandom), 1'b0);
    for (k = int'(K_DATA) + 1; k < 8; k++)
      queue_request(3'(k), 10'd1023, $urandom, 4'($urandom), 1'b1);

    // random traffic, mostly on a few busy lines so sequences build up
    n = 0;
    while (n < RANDOM_ITEMS) begin
      ln = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                       : hot_lines[$urandom_range(0, HOT_LINES - 1)];
      r = $urandom_range(0, 99);
      if (r < 28) kd = K_LOAD;
      else if (r < 56) kd = K_STORE;
      else if (r < 68) kd = K_GETS;
      else if (r < 80) kd = K_GETM;
      else if (r < 96) kd = K_DATA;
      else kd = 3'($urandom_range(int'(K_DATA) + 1, 7));
      queue_request(kd, ln, $urandom, 4'($urandom), 1'($urandom));
      n++;
      // a miss is usually followed by its fill, sometimes with a snoop in between
      if ((kd == K_LOAD || kd == K_STORE) && $urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 99) < 30) begin
          queue_request($urandom_range(0, 1) ? K_GETS : K_GETM, ln, $urandom,
                        4'($urandom), 1'($urandom));
          n++;
        end
        queue_request(K_DATA, ln, $urandom, 4'($urandom), 1'($urandom));
        n++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (requests_queued.size() > 0 || in_valid || outcomes_due.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
